// ===== sv/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque: request and response
// payloads, request codes and controller states.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 3;
   localparam int OFFSET_W  = 6;
   localparam int COUNT_W   = 6;

   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE = 3'd0,
      REQ_READ  = 3'd1,
      REQ_PEEK  = 3'd2,
      REQ_POP   = 3'd3,
      REQ_INDEX = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   req_type;
      logic [DATA_W-1:0]   write_value;
      logic [OFFSET_W-1:0] offset;
   } req_payload_type;

   typedef struct packed {
      logic                status;
      logic [DATA_W-1:0]   read_value;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
      logic                is_full;
   } rsp_payload_type;

endpackage

// ===== sv/ring_buffer_deque_top.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Ring buffer of 32-bit words with write, read-oldest, peek, pop-newest and
// indexed-read requests; one response per request.
// ----------------------------------------------------------------------------
// The buffer holds up to DEPTH-1 words in a single RAM with registered read
// data; one slot always stays empty to tell full from empty. Head and tail
// pointers count modulo DEPTH, which need not be a power of two. One request
// is in flight at a time. A request that reads a word (a successful read,
// peek, pop or indexed read) passes from the accepting edge through the RAM
// read (ST_LOAD) to the response (ST_SEND), which raises response valid; a
// write or an error response goes straight to ST_SEND. The input reopens in
// the cycle after the response is taken, so the next request waits for the
// response to the last one. Every response carries status (1 on error), the
// word read (zero on a write or an error), and the count and empty/full flags
// after the request.
module ring_buffer_deque_top #(
   parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rbd_pkg::req_payload_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rbd_pkg::rsp_payload_type rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int CMP_W = (CNT_W > rbd_pkg::OFFSET_W) ? CNT_W : rbd_pkg::OFFSET_W;
   localparam int SUM_W = CMP_W + 1;
   localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   // Controller and pointer state
   rbd_pkg::state_type       state_ff, state_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   rbd_pkg::rsp_payload_type rsp_ff, rsp_in;

   // Request decode
   logic                     accept;
   logic                     req_ok;
   logic                     needs_read;
   logic [CNT_W-1:0]         count_cur;
   logic [CNT_W-1:0]         count_new;
   logic [CMP_W-1:0]         count_wide;
   logic [CMP_W-1:0]         offset_wide;
   logic [SUM_W-1:0]         index_sum;
   logic [SUM_W-1:0]         index_wrap;
   logic [PTR_W-1:0]         head_inc;
   logic [PTR_W-1:0]         tail_inc;
   logic [PTR_W-1:0]         tail_dec;

   // RAM port signals
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [PTR_W-1:0]         ram_rd_addr;
   logic [rbd_pkg::DATA_W-1:0] ram_rd_data;

   rbd_ram #(
      .WIDTH (rbd_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_data.write_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept = req_valid && req_ready;

   // Stored count from the pointers; both stay below DEPTH
   always_comb begin
      if (tail_ff >= head_ff) begin
         count_cur = CNT_W'(tail_ff) - CNT_W'(head_ff);
      end else begin
         count_cur = CNT_W'(tail_ff) + DEPTH_CNT - CNT_W'(head_ff);
      end
   end

   // Pointer neighbors, wrapping at DEPTH
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + PTR_W'(1);
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + PTR_W'(1);
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - PTR_W'(1);

   // Indexed address: head plus offset stays below 2*DEPTH when in range
   assign count_wide  = CMP_W'(count_cur);
   assign offset_wide = CMP_W'(req_data.offset);
   assign index_sum   = SUM_W'(head_ff) + SUM_W'(offset_wide);
   assign index_wrap  = (index_sum >= DEPTH_SUM) ? index_sum - DEPTH_SUM : index_sum;

   // Decode the request: check it, pick the read address, move the pointers
   always_comb begin
      req_ok      = 1'b0;
      needs_read  = 1'b0;
      ram_rd_addr = head_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_new   = count_cur;
      unique case (req_data.req_type)
         rbd_pkg::REQ_WRITE: begin
            req_ok = (count_cur != FULL_CNT);
            if (req_ok) begin
               tail_in   = tail_inc;
               count_new = count_cur + CNT_W'(1);
            end
         end
         rbd_pkg::REQ_READ: begin
            req_ok     = (count_cur != '0);
            needs_read = req_ok;
            if (req_ok) begin
               head_in   = head_inc;
               count_new = count_cur - CNT_W'(1);
            end
         end
         rbd_pkg::REQ_PEEK: begin
            req_ok     = (count_cur != '0);
            needs_read = req_ok;
         end
         rbd_pkg::REQ_POP: begin
            req_ok      = (count_cur != '0);
            needs_read  = req_ok;
            ram_rd_addr = tail_dec;
            if (req_ok) begin
               tail_in   = tail_dec;
               count_new = count_cur - CNT_W'(1);
            end
         end
         rbd_pkg::REQ_INDEX: begin
            req_ok      = (offset_wide < count_wide);
            needs_read  = req_ok;
            ram_rd_addr = index_wrap[PTR_W-1:0];
         end
         default: begin
            req_ok = 1'b0;
         end
      endcase
   end

   assign ram_wr_en = accept && req_ok && (req_data.req_type == rbd_pkg::REQ_WRITE);
   assign ram_rd_en = accept && needs_read;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = needs_read ? rbd_pkg::ST_LOAD : rbd_pkg::ST_SEND;
            end
         end
         rbd_pkg::ST_LOAD: begin
            state_in = rbd_pkg::ST_SEND;
         end
         rbd_pkg::ST_SEND: begin
            if (rsp_ready) begin
               state_in = rbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbd_pkg::ST_IDLE;
         end
      endcase
   end

   // Response register: fill status and flags at accept, data after the read
   always_comb begin
      rsp_in = rsp_ff;
      if (accept) begin
         rsp_in.status      = !req_ok;
         rsp_in.read_value  = '0;
         rsp_in.entry_count = rbd_pkg::COUNT_W'(count_new);
         rsp_in.is_empty    = (count_new == '0);
         rsp_in.is_full     = (count_new == FULL_CNT);
      end else if (state_ff == rbd_pkg::ST_LOAD) begin
         rsp_in.read_value  = ram_rd_data;
      end
   end

   // Handshake outputs
   always_comb begin
      req_ready = (state_ff == rbd_pkg::ST_IDLE);
      rsp_valid = (state_ff == rbd_pkg::ST_SEND);
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbd_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= LAST_IDX) && (tail_ff <= LAST_IDX))
      else $error("pointer beyond DEPTH-1");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.read_value == '0)
      else $error("error response carries data");

   a_load_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbd_pkg::ST_LOAD |=> state_ff == rbd_pkg::ST_SEND)
      else $error("RAM read not followed by response");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("empty and full both set");
`endif

endmodule

// ===== sv/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = rbd_pkg::DATA_W,
   parameter int DEPTH = rbd_pkg::DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ring_buffer_deque_top. A directed table covers
// the empty buffer, data extremes, every request kind, the unused codes and
// indexed reads out of range. Random episodes follow: an opening one that
// wraps the tail down past slot zero and runs full and empty, then fill,
// drain, mixed traffic and noise. A shadow copy of the buffer predicts every
// response, and both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = rbd_pkg::DEPTH_DEF;
   localparam int ITEMS_WANTED = 1300;
   localparam int SETTLE_TAIL  = 8;            // response latency plus margin

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // codes with no request kind behind them; the block must answer an error
   localparam logic [rbd_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [rbd_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      rbd_pkg::req_payload_type req;
      bit                       typed;   // expected response written in the row
      rbd_pkg::rsp_payload_type rsp;
   } script_row_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   rbd_pkg::req_payload_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rbd_pkg::rsp_payload_type rsp_data;

   // shadow of the buffer, advanced as each request is accepted
   logic [rbd_pkg::DATA_W-1:0] shadow_words [DEPTH];
   int                         shadow_head = 0;
   int                         shadow_tail = 0;

   rbd_pkg::rsp_payload_type expected_rsp [$];
   script_row_type           script [$];
   int                       fail_count = 0;
   int                       issued     = 0;
   bit                       sender_calm = 1'b0;
   bit                       rsp_calm    = 1'b0;
   int                       hold_left   = 0;

   ring_buffer_deque_top #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic int shadow_count();
      return (shadow_tail + DEPTH - shadow_head) % DEPTH;
   endfunction

   // Predict the response to one request and advance the shadow buffer.
   function automatic rbd_pkg::rsp_payload_type buffer_step(rbd_pkg::req_payload_type r);
      int                       held;
      rbd_pkg::rsp_payload_type res;
      held       = shadow_count();
      res        = '0;
      res.status = STATUS_ERR;
      case (r.req_type)
         rbd_pkg::REQ_WRITE: if (held < DEPTH - 1) begin
            shadow_words[shadow_tail] = r.write_value;
            shadow_tail = (shadow_tail + 1) % DEPTH;
            res.status  = STATUS_OK;
         end
         rbd_pkg::REQ_READ: if (held != 0) begin
            res.read_value = shadow_words[shadow_head];
            shadow_head    = (shadow_head + 1) % DEPTH;
            res.status     = STATUS_OK;
         end
         rbd_pkg::REQ_PEEK: if (held != 0) begin
            res.read_value = shadow_words[shadow_head];
            res.status     = STATUS_OK;
         end
         rbd_pkg::REQ_POP: if (held != 0) begin
            shadow_tail    = (shadow_tail + DEPTH - 1) % DEPTH;
            res.read_value = shadow_words[shadow_tail];
            res.status     = STATUS_OK;
         end
         rbd_pkg::REQ_INDEX: if (int'(r.offset) < held) begin
            res.read_value = shadow_words[(shadow_head + int'(r.offset)) % DEPTH];
            res.status     = STATUS_OK;
         end
         default: ;
      endcase
      held            = shadow_count();
      res.entry_count = rbd_pkg::COUNT_W'(held);
      res.is_empty    = (held == 0);
      res.is_full     = (held == DEPTH - 1);
      return res;
   endfunction

   function automatic rbd_pkg::req_payload_type mk_req(
      logic [rbd_pkg::KIND_W-1:0]   kind,
      logic [rbd_pkg::DATA_W-1:0]   value,
      logic [rbd_pkg::OFFSET_W-1:0] off);
      rbd_pkg::req_payload_type r;
      r.req_type    = kind;
      r.write_value = value;
      r.offset      = off;
      return r;
   endfunction

   function automatic rbd_pkg::rsp_payload_type mk_rsp(
      logic st, logic [rbd_pkg::DATA_W-1:0] value,
      int cnt, logic empty, logic full);
      rbd_pkg::rsp_payload_type r;
      r.status      = st;
      r.read_value  = value;
      r.entry_count = rbd_pkg::COUNT_W'(cnt);
      r.is_empty    = empty;
      r.is_full     = full;
      return r;
   endfunction

   // Random content for a given kind; indexed reads land in range most of the time.
   function automatic rbd_pkg::req_payload_type random_request(
      logic [rbd_pkg::KIND_W-1:0] kind);
      logic [rbd_pkg::OFFSET_W-1:0] off;
      int                           held;
      held = shadow_count();
      off  = rbd_pkg::OFFSET_W'($urandom);
      if (kind == rbd_pkg::REQ_INDEX && held > 0 && $urandom_range(0, 4) != 0)
         off = rbd_pkg::OFFSET_W'($urandom_range(0, held - 1));
      return mk_req(kind, $urandom, off);
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 24);
      return $urandom_range(1, 3);
   endfunction

   // Drive one request, hold it until accepted, then queue its expected response.
   task automatic issue_request(input rbd_pkg::req_payload_type r, input bit typed,
                                input rbd_pkg::rsp_payload_type typed_rsp);
      rbd_pkg::rsp_payload_type predicted;
      int                       gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = buffer_step(r);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
      issued++;
      // flip between idle-free stretches and gappy ones
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = (!sender_calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_random(input logic [rbd_pkg::KIND_W-1:0] kind);
      issue_request(random_request(kind), 1'b0, '0);
   endtask

   // Drop valid and hold off until every outstanding response is back.
   task automatic settle_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // Response side: check every accepted response, stall ready at random.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t ns: response with nothing expected, got %p", $time, rsp_data);
               fail_count++;
            end else begin
               rbd_pkg::rsp_payload_type want;
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t ns: status expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $display("%0t ns: read_value expected %h, got %h",
                           $time, want.read_value, rsp_data.read_value);
                  fail_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $display("%0t ns: entry_count expected %0d, got %0d",
                           $time, want.entry_count, rsp_data.entry_count);
                  fail_count++;
               end
               if (rsp_data.is_empty !== want.is_empty) begin
                  $display("%0t ns: is_empty expected %0d, got %0d",
                           $time, want.is_empty, rsp_data.is_empty);
                  fail_count++;
               end
               if (rsp_data.is_full !== want.is_full) begin
                  $display("%0t ns: is_full expected %0d, got %0d",
                           $time, want.is_full, rsp_data.is_full);
                  fail_count++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 4) == 0) hold_left = pick_gap();
         end
      end
   end

   // Stimulus: reset, directed table, random episodes, drain.
   initial begin
      int                         pick;
      int                         n;
      logic [rbd_pkg::KIND_W-1:0] kind;

      // empty buffer: every read-type request and the unused codes must error
      script.push_back('{mk_req(rbd_pkg::REQ_READ, '0, '0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_PEEK, '0, '0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_POP, '1, '1), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, '0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(KIND_SPARE_LO, '1, '1), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(KIND_SPARE_HI, '0, '0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      // data extremes in, then every way of getting them out
      script.push_back('{mk_req(rbd_pkg::REQ_WRITE, '1, '0), 1'b1,
                         mk_rsp(STATUS_OK, '0, 1, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_WRITE, '0, '1), 1'b1,
                         mk_rsp(STATUS_OK, '0, 2, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_WRITE, 32'hA5A5_5A5A, '0), 1'b1,
                         mk_rsp(STATUS_OK, '0, 3, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_PEEK, '0, '0), 1'b1,
                         mk_rsp(STATUS_OK, '1, 3, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, 6'd0), 1'b1,
                         mk_rsp(STATUS_OK, '1, 3, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, 6'd2), 1'b1,
                         mk_rsp(STATUS_OK, 32'hA5A5_5A5A, 3, 1'b0, 1'b0)});
      // offset equal to the count and the largest offset are out of range
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, 6'd3), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 3, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '1, '1), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 3, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_POP, '0, '0), 1'b1,
                         mk_rsp(STATUS_OK, 32'hA5A5_5A5A, 2, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_READ, '0, '0), 1'b1,
                         mk_rsp(STATUS_OK, '1, 1, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, 6'd0), 1'b1,
                         mk_rsp(STATUS_OK, '0, 1, 1'b0, 1'b0)});
      script.push_back('{mk_req(KIND_SPARE_LO, '0, 6'd0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 1, 1'b0, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_READ, '1, '1), 1'b1,
                         mk_rsp(STATUS_OK, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_POP, '0, '0), 1'b1,
                         mk_rsp(STATUS_ERR, '0, 0, 1'b1, 1'b0)});
      script.push_back('{mk_req(rbd_pkg::REQ_WRITE, 32'h1234_5678, '1), 1'b0, '0});
      script.push_back('{mk_req(rbd_pkg::REQ_INDEX, '0, 6'd0), 1'b0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         issue_request(script[i].req, script[i].typed, script[i].rsp);

      settle_responses();

      // Opening episode: drain, write until the tail sits at slot zero, pop past
      // it so the tail wraps down, then fill to full, overrun, drain and underrun.
      while (shadow_count() != 0) issue_random(rbd_pkg::REQ_READ);
      while (!(shadow_tail == 0 && shadow_count() > 0) && shadow_count() < DEPTH - 1)
         issue_random(rbd_pkg::REQ_WRITE);
      issue_random(rbd_pkg::REQ_POP);
      issue_random(rbd_pkg::REQ_POP);
      while (shadow_count() < DEPTH - 1) issue_random(rbd_pkg::REQ_WRITE);
      issue_random(rbd_pkg::REQ_WRITE);
      issue_random(rbd_pkg::REQ_WRITE);
      issue_random(rbd_pkg::REQ_INDEX);
      while (shadow_count() != 0)
         issue_random($urandom_range(0, 1) ? rbd_pkg::REQ_READ : rbd_pkg::REQ_POP);
      issue_random(rbd_pkg::REQ_PEEK);
      issue_random(rbd_pkg::REQ_READ);

      while (issued < ITEMS_WANTED) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // fill to full, sometimes past it
            while (shadow_count() < DEPTH - 1) begin
               if ($urandom_range(0, 7) == 0) issue_random(rbd_pkg::REQ_INDEX);
               issue_random(rbd_pkg::REQ_WRITE);
            end
            repeat ($urandom_range(0, 2)) issue_random(rbd_pkg::REQ_WRITE);
         end else if (pick < 40) begin
            // drain from either end, sometimes past empty
            while (shadow_count() != 0) begin
               if ($urandom_range(0, 7) == 0) issue_random(rbd_pkg::REQ_PEEK);
               issue_random($urandom_range(0, 1) ? rbd_pkg::REQ_READ : rbd_pkg::REQ_POP);
            end
            repeat ($urandom_range(0, 2)) begin
               pick = $urandom_range(0, 2);
               issue_random(pick == 0 ? rbd_pkg::REQ_READ :
                            (pick == 1 ? rbd_pkg::REQ_PEEK : rbd_pkg::REQ_POP));
            end
         end else if (pick < 85) begin
            // mixed traffic around the current fill level
            n = $urandom_range(5, 40);
            repeat (n) begin
               pick = $urandom_range(0, 99);
               if (pick < 35)      kind = rbd_pkg::REQ_WRITE;
               else if (pick < 55) kind = rbd_pkg::REQ_READ;
               else if (pick < 65) kind = rbd_pkg::REQ_PEEK;
               else if (pick < 80) kind = rbd_pkg::REQ_POP;
               else                kind = rbd_pkg::REQ_INDEX;
               issue_random(kind);
            end
         end else begin
            // noise: any code, any value, any offset
            repeat ($urandom_range(1, 5))
               issue_request(mk_req(rbd_pkg::KIND_W'($urandom), $urandom,
                                    rbd_pkg::OFFSET_W'($urandom)),
                             1'b0, '0);
         end
         if ($urandom_range(0, 14) == 0) settle_responses();
      end

      // let the last responses come back, then allow for stragglers
      settle_responses();
      repeat (SETTLE_TAIL) @(posedge clock);

      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== ring_buffer_deque_top.f =====
sv/rbd_pkg.sv
sv/rbd_ram.sv
sv/ring_buffer_deque_top.sv
test/testbench.sv
